[design/fwpi_pkg.sv]
package fwpi_pkg;

    localparam int MotorCount = 4;
    localparam int CountWidth = 32;

    // signed Q8.16 limits and fixed constants
    localparam logic signed [23:0] QMax = 24'sh7FFFFF;
    localparam logic signed [23:0] QMin = -24'sh800000;
    localparam logic signed [24:0] TenQ16 = 25'sd655360;
    localparam logic [28:0] TenQ24 = 29'd167772160;
    localparam logic [CountWidth-1:0] CountReset = CountWidth'(2241);

    // register indexes
    localparam logic [1:0] RegPropGain = 2'd0;
    localparam logic [1:0] RegIntGain = 2'd1;
    localparam logic [1:0] RegSamplePeriod = 2'd2;
    localparam logic [1:0] RegCountsToRate = 2'd3;

    // bridge direction codes
    localparam logic [1:0] DirForward = 2'd0;
    localparam logic [1:0] DirBackward = 2'd1;
    localparam logic [1:0] DirRelease = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_S1,
        ST_S2,
        ST_S3,
        ST_S4,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [15:0] prop_gain;
        logic [15:0] int_gain;
        logic [15:0] sample_period;
        logic [19:0] counts_to_rate;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } lane_ctl_t;

    // round-half-up of b*20*65536/255 minus 10.0, as Q8.16
    // b*1310720 = 255*(5140*b) + 20*b, so only 20*b+127 needs the divide by 255
    function automatic logic signed [23:0] target_rate(input logic [7:0] b);
        logic [20:0] whole;
        logic [12:0] rem_num;
        logic [26:0] rem_prod;
        begin
            whole = 21'(b) * 21'd5140;
            rem_num = 13'(b) * 13'd20 + 13'd127;
            // floor(x/255) = (x*8225) >> 21 for x below 2^13
            rem_prod = 27'(rem_num) * 27'd8225;
            target_rate = 24'(signed'(25'(whole) + 25'(rem_prod[26:21])) - TenQ16);
        end
    endfunction

    function automatic logic signed [23:0] sat_q(input logic signed [63:0] v);
        begin
            if (v > 64'(QMax)) sat_q = QMax;
            else if (v < 64'(QMin)) sat_q = QMin;
            else sat_q = 24'(v);
        end
    endfunction

endpackage

[design/fwpi_if.sv]
interface fwpi_in_if;
    logic valid;
    logic ready;
    logic [7:0] setpoint_a;
    logic [7:0] setpoint_b;
    logic [7:0] setpoint_c;
    logic [7:0] setpoint_d;
    logic signed [31:0] count_a;
    logic signed [31:0] count_b;
    logic signed [31:0] count_c;
    logic signed [31:0] count_d;
    modport source (output valid, setpoint_a, setpoint_b, setpoint_c, setpoint_d,
        count_a, count_b, count_c, count_d, input ready);
    modport sink (input valid, setpoint_a, setpoint_b, setpoint_c, setpoint_d,
        count_a, count_b, count_c, count_d, output ready);
endinterface

interface fwpi_out_if;
    logic valid;
    logic ready;
    logic [7:0] duty_a;
    logic [7:0] duty_b;
    logic [7:0] duty_c;
    logic [7:0] duty_d;
    logic [1:0] direction_a;
    logic [1:0] direction_b;
    logic [1:0] direction_c;
    logic [1:0] direction_d;
    logic [7:0] speed_byte_a;
    logic [7:0] speed_byte_b;
    logic [7:0] speed_byte_c;
    logic [7:0] speed_byte_d;
    modport source (output valid, duty_a, duty_b, duty_c, duty_d, direction_a,
        direction_b, direction_c, direction_d, speed_byte_a, speed_byte_b,
        speed_byte_c, speed_byte_d, input ready);
    modport sink (input valid, duty_a, duty_b, duty_c, duty_d, direction_a,
        direction_b, direction_c, direction_d, speed_byte_a, speed_byte_b,
        speed_byte_c, speed_byte_d, output ready);
endinterface

[design/fwpi_lane.sv]
// One motor: measured rate, error, integral, control magnitude and bytes.
module fwpi_lane (
    input  logic                clk,
    input  logic                rst_n,
    input  fwpi_pkg::cfg_t      cfg,
    input  fwpi_pkg::lane_ctl_t ctl,
    input  logic [7:0]          setpoint,
    input  logic [31:0]         count,
    output logic [7:0]          duty,
    output logic [1:0]          direction,
    output logic [7:0]          speed_byte
);
    logic [fwpi_pkg::CountWidth-1:0] prev_reg;
    logic signed [23:0] integ_reg;
    logic signed [fwpi_pkg::CountWidth-1:0] diff_reg;
    logic [7:0] sp_reg;
    logic signed [23:0] target_reg;
    logic signed [23:0] rate_reg;
    logic signed [23:0] err_reg;
    logic signed [47:0] pterm_reg;
    logic signed [41:0] step_prod_reg;
    logic [28:0] mag_reg;
    logic [1:0] dir_reg;
    logic [7:0] sb_reg;

    logic [fwpi_pkg::CountWidth-1:0] cur;
    logic signed [63:0] rate_prod;
    logic signed [24:0] err_wide;
    logic signed [25:0] integ_sum;
    logic signed [24:0] step;
    logic signed [47:0] acc;
    logic [48:0] acc_abs;
    logic [33:0] duty_num;
    logic signed [35:0] sb_num;
    logic [35:0] sb_q;
    logic signed [47:0] iterm;

    assign cur = count[fwpi_pkg::CountWidth-1:0];
    assign rate_prod = 64'(diff_reg) * signed'(64'(cfg.counts_to_rate));
    assign err_wide = 25'(target_reg) - 25'(rate_reg);
    assign step = 25'(step_prod_reg >>> 16);
    assign integ_sum = 26'(integ_reg) + 26'(step);
    assign iterm = signed'(48'(cfg.int_gain)) * 48'(integ_reg);
    assign acc = pterm_reg + iterm;
    assign acc_abs = acc[47] ? 49'(-50'(acc)) : 49'(acc);
    // (x+10)*255/20 in Q.24 is (x+10)*51 >> 26
    assign duty_num = (34'(mag_reg) + 34'(fwpi_pkg::TenQ24)) * 34'd51;
    // (v+10)*255/20 in Q8.16 is (v+10)*51 >> 18
    assign sb_num = (36'(rate_reg) + 36'(fwpi_pkg::TenQ16)) * 36'sd51;
    assign sb_q = 36'(sb_num >>> 18);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= fwpi_pkg::CountReset;
            integ_reg <= '0;
        end
        else
        begin
            if (ctl.load) prev_reg <= cur;
            if (ctl.s3) integ_reg <= fwpi_pkg::sat_q(64'(integ_sum));
        end
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            diff_reg <= signed'(cur - prev_reg);
            sp_reg <= setpoint;
            target_reg <= fwpi_pkg::target_rate(setpoint);
        end
        if (ctl.s1) rate_reg <= fwpi_pkg::sat_q(rate_prod);
        if (ctl.s2)
        begin
            err_reg <= fwpi_pkg::sat_q(64'(err_wide));
            if (sp_reg >= 8'd141) dir_reg <= fwpi_pkg::DirForward;
            else if (sp_reg >= 8'd115) dir_reg <= fwpi_pkg::DirRelease;
            else dir_reg <= fwpi_pkg::DirBackward;
            if (sb_num < 0) sb_reg <= 8'd0;
            else if (sb_q > 36'd255) sb_reg <= 8'd255;
            else sb_reg <= sb_q[7:0];
        end
        if (ctl.s3)
        begin
            step_prod_reg <= '0;
            pterm_reg <= signed'(48'(cfg.prop_gain)) * 48'(err_reg);
        end
        else if (ctl.s2)
        begin
            step_prod_reg <= 42'(fwpi_pkg::sat_q(64'(err_wide)))
                * signed'(42'(cfg.sample_period));
        end
        if (ctl.s4)
        begin
            mag_reg <= (acc_abs > 49'(fwpi_pkg::TenQ24)) ? fwpi_pkg::TenQ24
                : acc_abs[28:0];
        end
    end

    // duty follows the held magnitude; forced to 0 on release
    assign duty = (dir_reg == fwpi_pkg::DirRelease) ? 8'd0 : 8'(duty_num >> 26);
    assign direction = dir_reg;
    assign speed_byte = sb_reg;
endmodule

[design/four_wheel_pi_speed_control_unit.sv]
// Channel   Dir  Payload
// in_ch     in   setpoint_a..d, count_a..d
// out_ch    out  duty_a..d, direction_a..d, speed_byte_a..d
// cfg       in   cfg_we, cfg_index, cfg_data
// A tick runs from input transfer through S1..S4 to result valid: rate, error,
// integral with proportional term, magnitude, then duty from the held magnitude.
// The sequencer goes back to idle after each result transfer.
// Four lanes run side by side; one tick is in flight at a time.
// A stalled result holds; the next tick is taken once it transfers.
// Reset restores config defaults, previous counts of 2241 and zero integrals.
module four_wheel_pi_speed_control_unit (
    input  logic        clk,
    input  logic        rst_n,
    fwpi_in_if.sink     in_ch,
    fwpi_out_if.source  out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data
);
    fwpi_pkg::state_t state_reg, state_next;
    fwpi_pkg::cfg_t cfg_reg;
    fwpi_pkg::lane_ctl_t ctl;
    logic [7:0] sp [fwpi_pkg::MotorCount];
    logic [31:0] cnt [fwpi_pkg::MotorCount];
    logic [7:0] duty [fwpi_pkg::MotorCount];
    logic [1:0] dir [fwpi_pkg::MotorCount];
    logic [7:0] sb [fwpi_pkg::MotorCount];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain <= 16'd4608;
            cfg_reg.int_gain <= 16'd1280;
            cfg_reg.sample_period <= 16'd655;
            cfg_reg.counts_to_rate <= 20'd9187;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fwpi_pkg::RegPropGain: cfg_reg.prop_gain <= cfg_data[15:0];
                fwpi_pkg::RegIntGain: cfg_reg.int_gain <= cfg_data[15:0];
                fwpi_pkg::RegSamplePeriod: cfg_reg.sample_period <= cfg_data[15:0];
                fwpi_pkg::RegCountsToRate: cfg_reg.counts_to_rate <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= fwpi_pkg::ST_IDLE;
        else state_reg <= state_next;
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fwpi_pkg::ST_IDLE: if (in_ch.valid) state_next = fwpi_pkg::ST_S1;
            fwpi_pkg::ST_S1: state_next = fwpi_pkg::ST_S2;
            fwpi_pkg::ST_S2: state_next = fwpi_pkg::ST_S3;
            fwpi_pkg::ST_S3: state_next = fwpi_pkg::ST_S4;
            fwpi_pkg::ST_S4: state_next = fwpi_pkg::ST_DONE;
            fwpi_pkg::ST_DONE: if (out_ch.ready) state_next = fwpi_pkg::ST_IDLE;
            default: state_next = fwpi_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        ctl = '0;
        in_ch.ready = 1'b0;
        out_ch.valid = 1'b0;
        unique case (state_reg)
            fwpi_pkg::ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                ctl.load = in_ch.valid;
            end
            fwpi_pkg::ST_S1: ctl.s1 = 1'b1;
            fwpi_pkg::ST_S2: ctl.s2 = 1'b1;
            fwpi_pkg::ST_S3: ctl.s3 = 1'b1;
            fwpi_pkg::ST_S4: ctl.s4 = 1'b1;
            fwpi_pkg::ST_DONE: out_ch.valid = 1'b1;
            default: ;
        endcase
    end

    assign sp[0] = in_ch.setpoint_a;
    assign sp[1] = in_ch.setpoint_b;
    assign sp[2] = in_ch.setpoint_c;
    assign sp[3] = in_ch.setpoint_d;
    assign cnt[0] = in_ch.count_a;
    assign cnt[1] = in_ch.count_b;
    assign cnt[2] = in_ch.count_c;
    assign cnt[3] = in_ch.count_d;

    // lanes
    for (genvar m = 0; m < fwpi_pkg::MotorCount; m++)
    begin : g_lane
        fwpi_lane u_lane (
            .clk(clk), .rst_n(rst_n), .cfg(cfg_reg), .ctl(ctl),
            .setpoint(sp[m]), .count(cnt[m]),
            .duty(duty[m]), .direction(dir[m]), .speed_byte(sb[m])
        );
    end

    assign out_ch.duty_a = duty[0];
    assign out_ch.duty_b = duty[1];
    assign out_ch.duty_c = duty[2];
    assign out_ch.duty_d = duty[3];
    assign out_ch.direction_a = dir[0];
    assign out_ch.direction_b = dir[1];
    assign out_ch.direction_c = dir[2];
    assign out_ch.direction_d = dir[3];
    assign out_ch.speed_byte_a = sb[0];
    assign out_ch.speed_byte_b = sb[1];
    assign out_ch.speed_byte_c = sb[2];
    assign out_ch.speed_byte_d = sb[3];
endmodule
